>>> sv/rvd_pkg.sv
// Shared constants and types for the radial vignette darkener.
`default_nettype none

package rvd_pkg;

	// Field and register widths
	localparam int CFG_W  = 13;   // frame_width / frame_height register width
	localparam int OPAC_W = 9;    // darkening register width
	localparam int CH_W   = 8;    // color channel width
	localparam int IDX_W  = 2;    // configuration index width

	// Fixed point: Q16 fraction, normalized distance a in 0..65536
	localparam int FRAC_W = 16;
	localparam int A_W    = FRAC_W + 1;
	localparam logic [A_W-1:0] ONE_Q16 = A_W'(65536);
	localparam logic [A_W-1:0] FACTOR_MIN = A_W'(19712);

	// Darkening gain: 179/256 stands for 0.7
	localparam int GAIN_W = 8;
	localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(179);
	localparam logic [OPAC_W-1:0] OPAC_MAX = OPAC_W'(256);

	// Default geometry limit
	localparam int MAX_DIM_DEF = 4096;

	// Register reset values
	localparam logic [CFG_W-1:0]  WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0]  HEIGHT_RST = CFG_W'(480);
	localparam logic [OPAC_W-1:0] DARK_RST   = OPAC_W'(230);

	// Configuration register indexes
	typedef logic [IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_WIDTH     = 2'd0;
	localparam cfg_idx_t REG_HEIGHT    = 2'd1;
	localparam cfg_idx_t REG_DARKENING = 2'd2;

endpackage

`default_nettype wire

>>> sv/radial_vignette_darkener.sv
// Accept to result valid: 2 squares and a sum, a 2-bit-per-cycle square root over RT_W = 22
//   steps, a 17-step restoring divide, 7 scaling steps, handoff.
// After reset or any register write the first pixel also computes the normalizing root in an
//   extra pass of the squares, sum and root steps; the result is cached until the next write.
// A new pixel is taken only after the previous result has been handed off, later on stalls.
// Reset: arst_n clears control, position, cached norm; registers load 640, 480, 230.
`default_nettype none

module radial_vignette_darkener #(
	parameter int MAX_DIM = rvd_pkg::MAX_DIM_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// pixel input
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [3*rvd_pkg::CH_W-1:0]  s_tdata,   // red_in, green_in, blue_in
	input  wire logic                        s_tuser,   // frame_start
	// pixel output
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [3*rvd_pkg::CH_W-1:0]       m_tdata,   // red_out, green_out, blue_out
	output logic                             m_tlast,   // frame_end
	// configuration writes
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [rvd_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [rvd_pkg::CFG_W-1:0]   cfg_data
);

	localparam int CH_W   = rvd_pkg::CH_W;
	localparam int CFG_W  = rvd_pkg::CFG_W;
	localparam int OPAC_W = rvd_pkg::OPAC_W;
	localparam int FRAC_W = rvd_pkg::FRAC_W;
	localparam int A_W    = rvd_pkg::A_W;
	localparam int GAIN_W = rvd_pkg::GAIN_W;

	localparam int DIM_W  = $clog2(MAX_DIM + 1);     // holds 1..MAX_DIM
	localparam int POS_W  = $clog2(MAX_DIM);         // holds 0..MAX_DIM-1
	localparam int EXT_W  = CFG_W + 1;               // register value next to MAX_DIM
	localparam int SQ_W   = 2 * DIM_W;
	localparam int RT_W   = DIM_W + 9;               // root width
	localparam int RAD_W  = 2 * RT_W;                // radicand width
	localparam int SUB_W  = RT_W + 2;
	localparam int MA_W   = (DIM_W > A_W + GAIN_W) ? DIM_W : A_W + GAIN_W;
	localparam int MB_W   = (DIM_W > A_W) ? DIM_W : A_W;
	localparam int P_W    = MA_W + MB_W;
	localparam int ITER_N = (RT_W > A_W) ? RT_W : A_W;
	localparam int CNT_W  = $clog2(ITER_N);

	typedef enum logic [3:0] {
		S_IDLE, S_SQX, S_SQY, S_SUM, S_SQRT, S_DIV, S_MUL1, S_MUL2,
		S_FACT, S_CH0, S_CH1, S_CH2, S_CH3, S_DONE
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  calc_m_q;
	logic                  m_valid_q;
	logic [CFG_W-1:0]      width_q;
	logic [CFG_W-1:0]      height_q;
	logic [OPAC_W-1:0]     dark_q;
	logic [POS_W-1:0]      col_q;
	logic [POS_W-1:0]      row_q;

	// datapath registers
	logic [CH_W-1:0]       red_q, green_q, blue_q;
	logic [CH_W-1:0]       res_r_q, res_g_q, res_b_q;
	logic                  last_q;
	logic [DIM_W-1:0]      dx_q, dy_q;
	logic [SQ_W-1:0]       acc_q;
	logic [P_W-1:0]        prod_q;
	logic [RAD_W-1:0]      rad_q;
	logic [RT_W-1:0]       root_q;
	logic [RT_W:0]         rem_q;
	logic [RT_W-1:0]       m_q;
	logic [A_W-1:0]        quo_q;
	logic [A_W-1:0]        factor_q;

	logic                  in_acc;
	logic                  cfg_acc;
	logic [DIM_W-1:0]      w_eff, h_eff;
	logic [EXT_W-1:0]      w_ext, h_ext;
	logic [OPAC_W-1:0]     op_eff;
	logic [DIM_W-1:0]      col_ext, row_ext;
	logic [DIM_W-1:0]      col_eff, row_eff;
	logic [DIM_W-1:0]      col_inc, row_inc;
	logic [DIM_W:0]        col2, row2;
	logic [DIM_W-1:0]      dx_new, dy_new;
	logic                  last_new;
	logic [MA_W-1:0]       mul_a;
	logic [MB_W-1:0]       mul_b;
	logic [SUB_W-1:0]      sub_a, sub_b;
	logic [SUB_W:0]        diff;
	logic                  ge;
	logic [RT_W:0]         div_cand;
	logic [RT_W-1:0]       root_new;
	logic [SQ_W:0]         sum_sq;
	logic                  sqrt_last;
	logic                  div_first;

	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	// Effective geometry: zero reads as 1, oversize reads as MAX_DIM
	assign w_ext = {1'b0, width_q};
	assign h_ext = {1'b0, height_q};
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (w_ext > EXT_W'(MAX_DIM)) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = w_ext[DIM_W-1:0];
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (h_ext > EXT_W'(MAX_DIM)) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = h_ext[DIM_W-1:0];
		end
	end
	assign op_eff = (dark_q > rvd_pkg::OPAC_MAX) ? rvd_pkg::OPAC_MAX : dark_q;

	// Position of the incoming pixel and the next one
	assign col_ext = DIM_W'(col_q);
	assign row_ext = DIM_W'(row_q);
	assign col_eff = (s_tuser || col_ext >= w_eff) ? '0 : col_ext;
	assign row_eff = (s_tuser || row_ext >= h_eff) ? '0 : row_ext;
	assign col_inc = col_eff + DIM_W'(1);
	assign row_inc = row_eff + DIM_W'(1);
	assign last_new = (col_eff == w_eff - DIM_W'(1)) && (row_eff == h_eff - DIM_W'(1));

	// Distance from center in doubled coordinates
	assign col2   = {col_eff, 1'b0};
	assign row2   = {row_eff, 1'b0};
	assign dx_new = (col2 >= {1'b0, w_eff}) ? DIM_W'(col2 - {1'b0, w_eff})
		: DIM_W'({1'b0, w_eff} - col2);
	assign dy_new = (row2 >= {1'b0, h_eff}) ? DIM_W'(row2 - {1'b0, h_eff})
		: DIM_W'({1'b0, h_eff} - row2);

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQX: begin
				mul_a = MA_W'(calc_m_q ? w_eff : dx_q);
				mul_b = MB_W'(calc_m_q ? w_eff : dx_q);
			end
			S_SQY: begin
				mul_a = MA_W'(calc_m_q ? h_eff : dy_q);
				mul_b = MB_W'(calc_m_q ? h_eff : dy_q);
			end
			S_MUL1: begin
				mul_a = MA_W'(quo_q);
				mul_b = MB_W'(rvd_pkg::GAIN);
			end
			S_MUL2: begin
				mul_a = MA_W'(prod_q[A_W+GAIN_W-1:0]);
				mul_b = MB_W'(op_eff);
			end
			S_CH0: begin
				mul_a = MA_W'(red_q);
				mul_b = MB_W'(factor_q);
			end
			S_CH1: begin
				mul_a = MA_W'(green_q);
				mul_b = MB_W'(factor_q);
			end
			S_CH2: begin
				mul_a = MA_W'(blue_q);
				mul_b = MB_W'(factor_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared subtractor: root trial in the square root, divisor trial in the divide
	assign div_first = (cnt_q == CNT_W'(A_W - 1));
	assign div_cand  = div_first ? rem_q : {rem_q[RT_W-1:0], 1'b0};
	always_comb begin
		if (state_q == S_DIV) begin
			sub_a = SUB_W'(div_cand);
			sub_b = SUB_W'(m_q);
		end else begin
			sub_a = {rem_q[RT_W-1:0], rad_q[RAD_W-1 -: 2]};
			sub_b = {root_q, 2'b01};
		end
	end
	assign diff      = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge        = !diff[SUB_W];
	assign root_new  = {root_q[RT_W-2:0], ge};
	assign sqrt_last = (state_q == S_SQRT) && (cnt_q == '0);
	assign sum_sq    = {1'b0, acc_q} + {1'b0, prod_q[SQ_W-1:0]};

	// Sequencer, position, registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			calc_m_q  <= 1'b0;
			m_valid_q <= 1'b0;
			width_q   <= rvd_pkg::WIDTH_RST;
			height_q  <= rvd_pkg::HEIGHT_RST;
			dark_q    <= rvd_pkg::DARK_RST;
			col_q     <= '0;
			row_q     <= '0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tlast   <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != S_DONE) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_acc) begin
				m_valid_q <= 1'b0;
				case (cfg_index)
					rvd_pkg::REG_WIDTH:     width_q  <= cfg_data;
					rvd_pkg::REG_HEIGHT:    height_q <= cfg_data;
					rvd_pkg::REG_DARKENING: dark_q   <= cfg_data[OPAC_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						calc_m_q <= !m_valid_q;
						state_q  <= S_SQX;
						if (col_inc == w_eff) begin
							col_q <= '0;
							row_q <= (row_inc == h_eff) ? '0 : row_inc[POS_W-1:0];
						end else begin
							col_q <= col_inc[POS_W-1:0];
							row_q <= row_eff[POS_W-1:0];
						end
					end
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: state_q <= S_SUM;
				S_SUM: begin
					cnt_q   <= CNT_W'(RT_W - 1);
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == '0) begin
						if (calc_m_q) begin
							calc_m_q  <= 1'b0;
							m_valid_q <= 1'b1;
							state_q   <= S_SQX;
						end else begin
							cnt_q   <= CNT_W'(A_W - 1);
							state_q <= S_DIV;
						end
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_MUL1;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_FACT;
				S_FACT: state_q <= S_CH0;
				S_CH0:  state_q <= S_CH1;
				S_CH1:  state_q <= S_CH2;
				S_CH2:  state_q <= S_CH3;
				S_CH3:  state_q <= S_DONE;
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {res_b_q, res_g_q, res_r_q};
						m_tlast  <= last_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= P_W'(mul_a) * P_W'(mul_b);
		if (in_acc) begin
			red_q   <= s_tdata[CH_W-1:0];
			green_q <= s_tdata[2*CH_W-1:CH_W];
			blue_q  <= s_tdata[3*CH_W-1:2*CH_W];
			last_q  <= last_new;
			dx_q    <= dx_new;
			dy_q    <= dy_new;
		end
		case (state_q)
			S_SQY: acc_q <= prod_q[SQ_W-1:0];
			S_SUM: begin
				rad_q  <= RAD_W'({sum_sq, FRAC_W'(0)});
				root_q <= '0;
				rem_q  <= '0;
			end
			S_SQRT: begin
				rad_q  <= rad_q << 2;
				root_q <= root_new;
				// distance root seeds the divide; otherwise keep the root remainder
				if (sqrt_last && !calc_m_q) begin
					rem_q <= (RT_W + 1)'(root_new);
				end else begin
					rem_q <= ge ? diff[RT_W:0] : sub_a[RT_W:0];
				end
				if (sqrt_last && calc_m_q) begin
					m_q <= root_new;
				end
			end
			S_DIV: begin
				rem_q <= ge ? diff[RT_W:0] : div_cand;
				quo_q <= {quo_q[A_W-2:0], ge};
			end
			S_FACT: factor_q <= rvd_pkg::ONE_Q16 - prod_q[FRAC_W +: A_W];
			S_CH1:  res_r_q <= prod_q[FRAC_W +: CH_W];
			S_CH2:  res_g_q <= prod_q[FRAC_W +: CH_W];
			S_CH3:  res_b_q <= prod_q[FRAC_W +: CH_W];
			default: ;
		endcase
	end

`ifndef SYNTH
	// No new request is taken while a pixel is in work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_tready)
		else $error("input accepted while sequencer busy");

	// A result appears only from the handoff state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_DONE))
		else $error("output valid raised outside handoff");

	// Cached norm is never zero, so the divide is defined
	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && state_q == S_DIV) |-> (m_q != '0))
		else $error("normalizing root is zero");

	// Normalized distance never exceeds 1.0
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1) |-> (quo_q <= rvd_pkg::ONE_Q16))
		else $error("normalized distance above one");

	// Darkening factor stays at or above its floor
	a_factor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CH0) |-> (factor_q >= rvd_pkg::FACTOR_MIN))
		else $error("darkening factor below floor");
`endif

endmodule

`default_nettype wire

>>> test/radial_vignette_darkener_tb.sv
// Self-checking testbench for radial_vignette_darkener: directed table, then random frames.
module radial_vignette_darkener_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CH_W   = rvd_pkg::CH_W;
	localparam int CFG_W  = rvd_pkg::CFG_W;
	localparam int OPAC_W = rvd_pkg::OPAC_W;
	typedef rvd_pkg::cfg_idx_t cfg_idx_t;
	localparam cfg_idx_t REG_WIDTH     = rvd_pkg::REG_WIDTH;
	localparam cfg_idx_t REG_HEIGHT    = rvd_pkg::REG_HEIGHT;
	localparam cfg_idx_t REG_DARKENING = rvd_pkg::REG_DARKENING;

	localparam int unsigned     RAND_ITEMS  = 1530;
	localparam int unsigned     CALM_ITEMS  = 150;
	localparam int unsigned     TAIL_CYCLES = 120;
	localparam longint unsigned CYCLE_LIMIT = 1_000_000;
	localparam cfg_idx_t        REG_SPARE   = 2'd3;   // index with no register behind it

	// Shading arithmetic
	localparam longint unsigned GAIN_Q8      = 179;    // 0.7 in Q0.8
	localparam longint unsigned OPACITY_FULL = 256;
	localparam longint unsigned UNITY_Q16    = 65536;
	localparam longint unsigned DIM_LIMIT    = 4096;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            frame_end;
	} shade_t;

	typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		cfg_idx_t         idx;
		logic [CFG_W-1:0] value;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic             frame_start;
		logic             typed;   // want holds a hand-computed result
		shade_t           want;
	} plan_row_t;

	localparam shade_t NO_WANT   = '0;
	localparam int     PLAN_ROWS = 31;

	// Directed stimulus, walked in order
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// reset geometry 640x480, darkening 230
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1,
			'{8'd0, 8'd0, 8'd0, 1'b0}},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd255, 8'd0, 8'd128, 1'b0, 1'b0, NO_WANT},
		// no darkening passes pixels through
		'{ROW_WRITE, REG_DARKENING, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd255, 8'd170, 8'd85, 1'b0, 1'b1,
			'{8'd255, 8'd170, 8'd85, 1'b0}},
		// 2x2 frame at full darkening, last pixel sits on the center
		'{ROW_WRITE, REG_WIDTH, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_HEIGHT, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_DARKENING, 13'd256, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd1, 8'd2, 8'd3, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd200, 8'd100, 8'd50, 1'b0, 1'b1,
			'{8'd200, 8'd100, 8'd50, 1'b1}},
		// zero size acts as 1x1
		'{ROW_WRITE, REG_WIDTH, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_HEIGHT, 13'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, NO_WANT},
		// oversized width and darkening saturate
		'{ROW_WRITE, REG_WIDTH, 13'd8191, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_HEIGHT, 13'd4096, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_DARKENING, 13'd8191, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, NO_WANT},
		// write to an unused index changes nothing
		'{ROW_WRITE, REG_SPARE, 13'h1ABC, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		// shrink width, then height, with the position past the new edge
		'{ROW_WRITE, REG_WIDTH, 13'd10, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd127, 8'd127, 8'd127, 1'b1, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd64, 8'd32, 8'd16, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd8, 8'd4, 8'd2, 1'b0, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_WIDTH, 13'd2, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd170, 8'd170, 8'd85, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd85, 8'd170, 8'd85, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd18, 8'd52, 8'd86, 1'b0, 1'b0, NO_WANT},
		'{ROW_WRITE, REG_HEIGHT, 13'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, NO_WANT},
		'{ROW_PIXEL, REG_WIDTH, 13'd0, 8'd254, 8'd220, 8'd186, 1'b0, 1'b0, NO_WANT}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [3*CH_W-1:0]   s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [3*CH_W-1:0]   m_tdata;
	logic                m_tlast;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = REG_WIDTH;
	logic [CFG_W-1:0]    cfg_data = '0;

	// Predictor copy of registers and raster position
	logic [CFG_W-1:0]    width_reg = 13'd640;
	logic [CFG_W-1:0]    height_reg = 13'd480;
	logic [OPAC_W-1:0]   dark_reg = 9'd230;
	logic [CFG_W-1:0]    col_pos = '0;
	logic [CFG_W-1:0]    row_pos = '0;
	shade_t              shade_due[$];

	bit                  calm = 1'b0;       // no idling on either side
	logic                typed_on = 1'b0;
	shade_t              typed_want = '0;
	int unsigned         stall_left = 0;
	int unsigned         pixels_in = 0;
	int unsigned         pixels_out = 0;
	int unsigned         frame_ends = 0;
	int unsigned         reg_writes = 0;
	int unsigned         mismatches = 0;
	longint unsigned     cycles = 0;

	radial_vignette_darkener DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Bitwise integer square root
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned acc, probe, rem;
		acc = 0;
		rem = v;
		probe = 64'd1 << 62;
		while (probe > rem)
			probe >>= 2;
		while (probe != 0) begin
			if (rem >= acc + probe) begin
				rem -= acc + probe;
				acc = (acc >> 1) + probe;
			end else begin
				acc >>= 1;
			end
			probe >>= 2;
		end
		return acc;
	endfunction

	function automatic longint unsigned clip_dim(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return v;
	endfunction

	// Darkens one pixel and advances the raster position
	function automatic shade_t shade_pixel(input logic [CH_W-1:0] r, g, b, input logic fs);
		longint unsigned w, h, op, dx, dy, d, m, a, cut, factor;
		longint          sx, sy;
		shade_t          o;
		w = clip_dim(width_reg);
		h = clip_dim(height_reg);
		op = (dark_reg > OPACITY_FULL) ? OPACITY_FULL : longint'(dark_reg);
		if (fs) begin
			col_pos = '0;
			row_pos = '0;
		end
		if (col_pos >= w)
			col_pos = '0;
		if (row_pos >= h)
			row_pos = '0;
		// doubled coordinates relative to the center
		sx = 2 * longint'(col_pos) - longint'(w);
		sy = 2 * longint'(row_pos) - longint'(h);
		dx = (sx < 0) ? -sx : sx;
		dy = (sy < 0) ? -sy : sy;
		d = int_sqrt((dx * dx + dy * dy) << 16);
		m = int_sqrt((w * w + h * h) << 16);
		a = (d << 16) / m;
		cut = (a * GAIN_Q8 * op) >> 16;
		factor = UNITY_Q16 - cut;
		o.red = CH_W'((r * factor) >> 16);
		o.green = CH_W'((g * factor) >> 16);
		o.blue = CH_W'((b * factor) >> 16);
		o.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
		col_pos = col_pos + 1'b1;
		if (col_pos >= w) begin
			col_pos = '0;
			row_pos = row_pos + 1'b1;
			if (row_pos >= h)
				row_pos = '0;
		end
		return o;
	endfunction

	function automatic logic [CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	// Mostly small frames so frame ends come often, now and then the extremes
	function automatic logic [CFG_W-1:0] rand_dim();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: return CFG_W'($urandom_range(1, 8));
			7: return CFG_W'($urandom_range(1, 64));
			8: begin
				case ($urandom_range(0, 4))
					0: return CFG_W'(0);
					1: return CFG_W'(1);
					2: return CFG_W'(4096);
					3: return CFG_W'(4097);
					default: return CFG_W'(8191);
				endcase
			end
			default: return CFG_W'($urandom_range(0, 8191));
		endcase
	endfunction

	// Holds off new pixels until every pending result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (shade_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		drain();
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offers one pixel request, with an occasional gap before it
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input logic fs,
			input logic typed, input shade_t want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7))
				@(negedge clk);
		end
		typed_on = typed;
		typed_want = want;
		s_tdata <= {b, g, r};
		s_tuser <= fs;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Receiver stalls in bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (calm) begin
			stall_left <= 0;
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result check, register tracking and prediction at each accepted request
	always @(posedge clk) begin
		shade_t got, want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[CH_W-1:0], m_tdata[2*CH_W-1:CH_W],
					m_tdata[3*CH_W-1:2*CH_W], m_tlast};
				pixels_out++;
				if (m_tlast)
					frame_ends++;
				if (shade_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected none, got r=%0d g=%0d b=%0d end=%0d",
							pixels_out, got.red, got.green, got.blue, got.frame_end);
				end else begin
					want = shade_due.pop_front();
					if (got.red != want.red || got.green != want.green ||
							got.blue != want.blue || got.frame_end != want.frame_end) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("result %0d: expected r=%0d g=%0d b=%0d end=%0d,",
								pixels_out, want.red, want.green, want.blue,
								want.frame_end);
							$display(" got r=%0d g=%0d b=%0d end=%0d",
								got.red, got.green, got.blue, got.frame_end);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					REG_WIDTH: width_reg = cfg_data;
					REG_HEIGHT: height_reg = cfg_data;
					REG_DARKENING: dark_reg = cfg_data[OPAC_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				want = shade_pixel(s_tdata[CH_W-1:0], s_tdata[2*CH_W-1:CH_W],
					s_tdata[3*CH_W-1:2*CH_W], s_tuser);
				if (typed_on)
					want = typed_want;
				shade_due = {shade_due, want};
				pixels_in++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		longint unsigned frame_px;
		int unsigned     sent, run, cut_at;
		logic [CFG_W-1:0] dark;
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_WRITE)
				write_reg(PLAN[i].idx, PLAN[i].value);
			else
				send_pixel(PLAN[i].red, PLAN[i].green, PLAN[i].blue, PLAN[i].frame_start,
					PLAN[i].typed, PLAN[i].want);
		end

		// random phases: new settings, then frames or loose pixels
		sent = 0;
		while (sent < RAND_ITEMS) begin
			calm = (sent + CALM_ITEMS >= RAND_ITEMS) || ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_WIDTH, rand_dim());
			if ($urandom_range(0, 1) == 0)
				write_reg(REG_HEIGHT, rand_dim());
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 5))
					0: dark = '0;
					1: dark = 13'd256;
					2: dark = CFG_W'($urandom_range(257, 8191));
					default: dark = CFG_W'($urandom_range(0, 256));
				endcase
				write_reg(REG_DARKENING, dark);
			end
			if ($urandom_range(0, 29) == 0)
				write_reg(REG_SPARE, CFG_W'($urandom));

			frame_px = clip_dim(width_reg) * clip_dim(height_reg);
			if (frame_px <= 100 && $urandom_range(0, 4) != 0) begin
				// whole frames opened by frame_start, now and then cut short
				repeat ($urandom_range(1, 3)) begin
					cut_at = int'(frame_px);
					if ($urandom_range(0, 5) == 0)
						cut_at = $urandom_range(1, int'(frame_px));
					for (int k = 0; k < cut_at; k++) begin
						send_pixel(rand_chan(), rand_chan(), rand_chan(), k == 0, 1'b0, NO_WANT);
						sent++;
					end
				end
			end else begin
				// loose pixels with stray frame starts
				run = $urandom_range(1, 40);
				for (int k = 0; k < run; k++) begin
					send_pixel(rand_chan(), rand_chan(), rand_chan(),
						(k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 15) == 0,
						1'b0, NO_WANT);
					sent++;
				end
			end
			if ($urandom_range(0, 9) == 0)
				drain();
		end

		drain();
		repeat (TAIL_CYCLES)
			@(negedge clk);
		$display("%0d pixels in, %0d out, %0d frame ends, %0d register writes, %0d mismatches",
			pixels_in, pixels_out, frame_ends, reg_writes, mismatches);
		$display("Sizes 1x1 up to saturated 4096, darkening 0 to beyond full, resize mid-frame");
		if (mismatches == 0 && shade_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
